/* sv/assert_macros.svh */
// Assertion macros used by the verification checker of the page cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("page cache assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("page cache assertion failed");

`endif

/* sv/cflru_pkg.sv */
package cflru_pkg;

   // Fixed field and register widths.
   localparam int PAGE_W    = 32;
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 1'b1;

   // Register reset values.
   localparam logic [CSR_W-1:0] CAPACITY_RESET = 7'd64;
   localparam logic [CSR_W-1:0] WINDOW_RESET   = 7'd32;

   // Commands from the sequencer to one cell.
   typedef struct packed {
      logic look;
      logic shift;
   } cell_ctrl_type;

   // What one cell reports back to the sequencer.
   typedef struct packed {
      logic valid;
      logic dirty;
      logic match;
      logic cand;
   } cell_stat_type;

endpackage

/* sv/cflru_cell.sv */
module cflru_cell
   import cflru_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int OCC_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [PAGE_W-1:0] req_page,
   input  logic [OCC_W-1:0]  win_lo,
   input  logic [PAGE_W-1:0] nb_page,
   input  logic              nb_dirty,
   input  logic              nb_valid,
   output logic [PAGE_W-1:0] page_out,
   output cell_stat_type     stat
);

   logic [PAGE_W-1:0] page_ff, page_in;
   logic              dirty_ff, dirty_in;
   logic              valid_ff, valid_in;
   logic              match_ff, match_in;
   logic              cand_ff, cand_in;

   // The look step compares the slot; the shift step takes the neighbor's entry.
   always_comb begin
      page_in  = page_ff;
      dirty_in = dirty_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      cand_in  = cand_ff;
      if (ctrl.look) begin
         match_in = valid_ff && (page_ff == req_page);
         cand_in  = valid_ff && !dirty_ff && (OCC_W'(INDEX) >= win_lo);
      end
      if (ctrl.shift) begin
         page_in  = nb_page;
         dirty_in = nb_dirty;
         valid_in = nb_valid;
      end
   end

   // Control state is cleared by reset; the page payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b0;
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         cand_ff  <= 1'b0;
      end else begin
         dirty_ff <= dirty_in;
         valid_ff <= valid_in;
         match_ff <= match_in;
         cand_ff  <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign page_out   = page_ff;
   assign stat.valid = valid_ff;
   assign stat.dirty = dirty_ff;
   assign stat.match = match_ff;
   assign stat.cand  = cand_ff;

endmodule

/* sv/clean_first_lru_page_cache.sv */
// Clean-first LRU page cache. The recency list is a row of MAX_ENTRIES cells,
// slot 0 at the MRU end; each cell holds one page number with its dirty and
// valid bits, so reset leaves the cache empty at once and no clearing pass is
// needed. A request beat passes through a look state and a move state: in the
// look state, every cell compares its page with the request and checks whether
// it is a clean entry inside the scan window; in the move state, the sequencer
// picks the hit slot, the clean victim, the LRU victim or the first free slot,
// and every cell at or below that slot takes its neighbor's entry while the new
// page enters slot 0. The result beat is registered as the move state ends,
// and the next request beat can be accepted during that same cycle, so the
// move state goes straight back to look while results are taken. Configuration
// writes are taken at any time but are meant to be issued while the block is idle.
module clean_first_lru_page_cache
   import cflru_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PAGE_W-1:0]    req_page_number,
   input  logic                 req_operation,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic                 rsp_victim_valid,
   output logic [PAGE_W-1:0]    rsp_victim_page,
   output logic                 rsp_victim_writeback
);

   localparam int N     = MAX_ENTRIES;
   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
   localparam int CW    = (OCC_W > CSR_W) ? OCC_W : CSR_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_MOVE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  cap_ff, cap_in;
   logic [CSR_W-1:0]  win_ff, win_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              write_ff, write_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_vv_ff, rsp_vv_in;
   logic [PAGE_W-1:0] rsp_vpage_ff, rsp_vpage_in;
   logic              rsp_wb_ff, rsp_wb_in;

   logic              accept;
   logic              advance;
   logic              move_done;
   logic [CW-1:0]     occ_x, cap_x, win_x, win_c;
   logic [OCC_W-1:0]  win_lo;
   logic              full;
   logic              hit;
   logic              evict;
   logic              any_cand;
   logic              ins_dirty;
   logic              sel_dirty;
   logic [PAGE_W-1:0] sel_page;
   logic [N-1:0]      match_v, cand_v, valid_v, dirty_v;
   logic [N-1:0]      sel_flags, mask, onehot;

   cell_ctrl_type     ctrl [N];
   cell_stat_type     stat [N];
   logic [PAGE_W-1:0] cell_page [N];

   // Handshake: a new request may enter while the previous one finishes.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign move_done = (state_ff == ST_MOVE) && advance;
   assign req_ready = (state_ff == ST_IDLE) || move_done;
   assign accept    = req_valid && req_ready;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            if (advance) state_in = accept ? ST_LOOK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration registers; an unknown index leaves both unchanged.
   always_comb begin
      cap_in = cap_ff;
      win_in = win_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: cap_in = csr_wdata;
            CSR_WINDOW:   win_in = csr_wdata;
            default:      ;
         endcase
      end
   end

   // Effective capacity and the lowest slot inside the scan window.
   always_comb begin
      occ_x = CW'(occ_ff);
      win_x = CW'(win_ff);
      if (cap_ff == '0)            cap_x = CW'(1);
      else if (CW'(cap_ff) > MAX_C) cap_x = MAX_C;
      else                         cap_x = CW'(cap_ff);
      win_c  = (win_x > occ_x) ? occ_x : win_x;
      win_lo = OCC_W'(occ_x - win_c);
      full   = occ_x >= cap_x;
   end

   // Gather the flags that the cells registered in the look cycle.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         match_v[i] = stat[i].match;
         cand_v[i]  = stat[i].cand;
         valid_v[i] = stat[i].valid;
         dirty_v[i] = stat[i].dirty;
      end
   end

   // Pick the slot that leaves the list: hit, clean victim, LRU entry or the
   // first free slot. Its flags turn into a mask of every slot at or below it.
   always_comb begin
      hit      = |match_v;
      evict    = !hit && full;
      any_cand = |cand_v;
      if (hit)           sel_flags = match_v;
      else if (evict)    sel_flags = any_cand ? cand_v : valid_v;
      else               sel_flags = {valid_v[N-2:0], 1'b1};
      for (int i = 0; i < N; i++) begin
         mask[i] = |(sel_flags >> i);
      end
      onehot = mask & ~(mask >> 1);
   end

   // Read out the entry in the selected slot.
   always_comb begin
      sel_page  = '0;
      sel_dirty = 1'b0;
      for (int i = 0; i < N; i++) begin
         sel_page  = sel_page | ({PAGE_W{onehot[i]}} & cell_page[i]);
         sel_dirty = sel_dirty | (onehot[i] & dirty_v[i]);
      end
      ins_dirty = write_ff || (hit && sel_dirty);
   end

   // The row of cells; slot 0 takes the new entry from the sequencer.
   for (genvar g = 0; g < N; g++) begin : g_cell
      logic [PAGE_W-1:0] nb_page;
      logic              nb_dirty;
      logic              nb_valid;

      if (g == 0) begin : g_head
         assign nb_page  = page_ff;
         assign nb_dirty = ins_dirty;
         assign nb_valid = 1'b1;
      end else begin : g_body
         assign nb_page  = cell_page[g-1];
         assign nb_dirty = stat[g-1].dirty;
         assign nb_valid = stat[g-1].valid;
      end

      assign ctrl[g].look  = (state_ff == ST_LOOK);
      assign ctrl[g].shift = move_done && mask[g];

      cflru_cell #(
         .INDEX (g),
         .OCC_W (OCC_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl[g]),
         .req_page (page_ff),
         .win_lo   (win_lo),
         .nb_page  (nb_page),
         .nb_dirty (nb_dirty),
         .nb_valid (nb_valid),
         .page_out (cell_page[g]),
         .stat     (stat[g])
      );
   end

   // Request capture, occupancy and the result register.
   always_comb begin
      page_in      = page_ff;
      write_in     = write_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_vv_in    = rsp_vv_ff;
      rsp_vpage_in = rsp_vpage_ff;
      rsp_wb_in    = rsp_wb_ff;
      if (move_done) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit;
         rsp_vv_in    = evict;
         rsp_vpage_in = evict ? sel_page : '0;
         rsp_wb_in    = evict && sel_dirty;
         if (!hit && !evict) occ_in = occ_ff + OCC_W'(1);
      end
      if (accept) begin
         page_in  = req_page_number;
         write_in = !req_operation;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAPACITY_RESET;
         win_ff       <= WINDOW_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         win_ff       <= win_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      write_ff     <= write_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_vv_ff    <= rsp_vv_in;
      rsp_vpage_ff <= rsp_vpage_in;
      rsp_wb_ff    <= rsp_wb_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_victim_valid     = rsp_vv_ff;
   assign rsp_victim_page      = rsp_vpage_ff;
   assign rsp_victim_writeback = rsp_wb_ff;

endmodule

/* sv/cflru_checker.sv */
`include "assert_macros.svh"

module cflru_checker
   import cflru_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_hit,
   input logic              rsp_victim_valid,
   input logic [PAGE_W-1:0] rsp_victim_page,
   input logic              rsp_victim_writeback
);

   // A stalled result beat stays valid and keeps its hit flag and victim page.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_victim_page))

   // A hit never evicts, and its victim fields read as zero.
   `ASSERT_IMPLY(a_hit_no_victim, clock, reset, rsp_valid && rsp_hit, !rsp_victim_valid && !rsp_victim_writeback && (rsp_victim_page == '0))

   // A writeback is only flagged for an evicted entry.
   `ASSERT_IMPLY(a_wb_needs_victim, clock, reset, rsp_valid && rsp_victim_writeback, rsp_victim_valid)

   // The compare cycle follows every accepted request beat.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind clean_first_lru_page_cache cflru_checker u_cflru_checker (.*);
